@@ rtl/assert_macros.svh @@
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with synchronous reset held off
`define LDL_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// the same on the default clock and reset names
`define LDL_ASSERT(label, prop, msg) \
   `LDL_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

@@ rtl/ldl_pkg.sv @@
// ----------------------------------------------------------------------------
// ldl_pkg
// shared widths, mode codes, controller commands and status for the
// layer ordered display list
// ----------------------------------------------------------------------------
package ldl_pkg;

   localparam int SLOTS_DEF = 512;

   localparam int MODE_W  = 3;
   localparam int TAG_W   = 32;
   localparam int LAYER_W = 16;
   localparam int SLOT_W  = 9;
   localparam int CNT_W   = 10;

   localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RELAYER = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SORT    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_READ    = 3'd5;

   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
   localparam logic [OP_W-1:0] OP_ACCEPT   = 5'd1;
   localparam logic [OP_W-1:0] OP_CLR_STEP = 5'd2;
   localparam logic [OP_W-1:0] OP_CLR_END  = 5'd3;
   localparam logic [OP_W-1:0] OP_INS_RD   = 5'd4;
   localparam logic [OP_W-1:0] OP_INS_TAKE = 5'd5;
   localparam logic [OP_W-1:0] OP_W_RD     = 5'd6;
   localparam logic [OP_W-1:0] OP_SPL_EV   = 5'd7;
   localparam logic [OP_W-1:0] OP_SPL_W1   = 5'd8;
   localparam logic [OP_W-1:0] OP_SPL_W2   = 5'd9;
   localparam logic [OP_W-1:0] OP_INS_FIN  = 5'd10;
   localparam logic [OP_W-1:0] OP_FND_EV   = 5'd11;
   localparam logic [OP_W-1:0] OP_RLY_W    = 5'd12;
   localparam logic [OP_W-1:0] OP_RM_W1    = 5'd13;
   localparam logic [OP_W-1:0] OP_RM_W2    = 5'd14;
   localparam logic [OP_W-1:0] OP_SRT_RD0  = 5'd15;
   localparam logic [OP_W-1:0] OP_SRT_INIT = 5'd16;
   localparam logic [OP_W-1:0] OP_SRT_RD   = 5'd17;
   localparam logic [OP_W-1:0] OP_SRT_EV   = 5'd18;
   localparam logic [OP_W-1:0] OP_SRT_ADV  = 5'd19;
   localparam logic [OP_W-1:0] OP_RD_RD    = 5'd20;
   localparam logic [OP_W-1:0] OP_RD_EV    = 5'd21;
   localparam logic [OP_W-1:0] OP_RD_OUT   = 5'd22;
   localparam logic [OP_W-1:0] OP_DONE     = 5'd23;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              free_ok;
      logic              head_ok;
      logic              w_go;
      logic              layer_le;
      logic              tag_hit;
      logic              s_go;
      logic              sort_less;
      logic              slot_ok;
      logic              clr_last;
   } status_type;

endpackage

@@ rtl/layer_ordered_display_list_top.sv @@
// ----------------------------------------------------------------------------
// layer_ordered_display_list_top
// slot pool linked into a free list and a display list kept in stable
// ascending layer order; insert, remove, relayer, sort pass, clear, read
//
//   channel | ports | moves
//   req     | req_* | one command item in
//   rsp     | rsp_* | one result item out per command item
//
// one item at a time; a list walk reads each entry visited and then evaluates it
// (one read address shared by the link, tag and layer memories)
// reset and clear sweep the memories with req_ready low
// a stalled result holds the next item in its final state until taken
// ----------------------------------------------------------------------------
module layer_ordered_display_list_top import ldl_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [TAG_W-1:0]   req_tag,
   input  logic [LAYER_W-1:0] req_layer,
   input  logic [SLOT_W-1:0]  req_slot,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_ok,
   output logic [CNT_W-1:0]   rsp_count,
   output logic [CNT_W-1:0]   rsp_head_slot,
   output logic [TAG_W-1:0]   rsp_entry_tag,
   output logic [LAYER_W-1:0] rsp_entry_layer,
   output logic [CNT_W-1:0]   rsp_next_slot
);

   cmd_type    cmd;
   status_type status;

   ldl_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_mode(req_mode), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .status(status), .cmd(cmd)
   );

   ldl_dp #(.SLOTS(SLOTS)) u_dp (
      .clock(clock), .reset(reset),
      .cmd(cmd), .status(status),
      .req_mode(req_mode), .req_tag(req_tag), .req_layer(req_layer),
      .req_slot(req_slot),
      .rsp_ok(rsp_ok), .rsp_count(rsp_count), .rsp_head_slot(rsp_head_slot),
      .rsp_entry_tag(rsp_entry_tag), .rsp_entry_layer(rsp_entry_layer),
      .rsp_next_slot(rsp_next_slot)
   );

endmodule

@@ rtl/ldl_ram.sv @@
// ----------------------------------------------------------------------------
// ldl_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module ldl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ldl_ctrl.sv @@
// ----------------------------------------------------------------------------
// ldl_ctrl
// sequencer for list walks, splices, clearing sweep and result handshake
// ----------------------------------------------------------------------------
module ldl_ctrl import ldl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [MODE_W-1:0] req_mode,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  status_type        status,
   output cmd_type           cmd
);

   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_CLR      = 5'd1;
   localparam logic [4:0] ST_CLR_END  = 5'd2;
   localparam logic [4:0] ST_INS_RD   = 5'd3;
   localparam logic [4:0] ST_INS_TAKE = 5'd4;
   localparam logic [4:0] ST_SPL_RD   = 5'd5;
   localparam logic [4:0] ST_SPL_EV   = 5'd6;
   localparam logic [4:0] ST_SPL_W1   = 5'd7;
   localparam logic [4:0] ST_SPL_W2   = 5'd8;
   localparam logic [4:0] ST_INS_FIN  = 5'd9;
   localparam logic [4:0] ST_FND_RD   = 5'd10;
   localparam logic [4:0] ST_FND_EV   = 5'd11;
   localparam logic [4:0] ST_RLY_W    = 5'd12;
   localparam logic [4:0] ST_RM_W1    = 5'd13;
   localparam logic [4:0] ST_RM_W2    = 5'd14;
   localparam logic [4:0] ST_SRT_RD0  = 5'd15;
   localparam logic [4:0] ST_SRT_INIT = 5'd16;
   localparam logic [4:0] ST_SRT_RD   = 5'd17;
   localparam logic [4:0] ST_SRT_EV   = 5'd18;
   localparam logic [4:0] ST_SRT_ADV  = 5'd19;
   localparam logic [4:0] ST_RD_RD    = 5'd20;
   localparam logic [4:0] ST_RD_EV    = 5'd21;
   localparam logic [4:0] ST_DONE     = 5'd22;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       clr_item_ff, clr_item_in;

   always_comb begin
      state_in     = state_ff;
      clr_item_in  = clr_item_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd.op       = OP_NONE;
      req_ready    = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_ACCEPT;
               unique case (req_mode)
                  MODE_CLEAR: begin
                     state_in    = ST_CLR;
                     clr_item_in = 1'b1;
                  end
                  MODE_INSERT:  state_in = ST_INS_RD;
                  MODE_REMOVE:  state_in = ST_FND_RD;
                  MODE_RELAYER: state_in = ST_FND_RD;
                  MODE_SORT:    state_in = ST_SRT_RD0;
                  MODE_READ:    state_in = ST_RD_RD;
                  default:      state_in = ST_DONE;
               endcase
            end
         end
         ST_CLR: begin
            cmd.op = OP_CLR_STEP;
            if (status.clr_last) begin
               state_in = ST_CLR_END;
            end
         end
         ST_CLR_END: begin
            cmd.op   = OP_CLR_END;
            state_in = clr_item_ff ? ST_DONE : ST_IDLE;
         end
         ST_INS_RD: begin
            if (status.free_ok) begin
               cmd.op   = OP_INS_RD;
               state_in = ST_INS_TAKE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_INS_TAKE: begin
            cmd.op   = OP_INS_TAKE;
            state_in = ST_SPL_RD;
         end
         ST_SPL_RD: begin
            if (status.w_go) begin
               cmd.op   = OP_W_RD;
               state_in = ST_SPL_EV;
            end else begin
               state_in = ST_SPL_W1;
            end
         end
         ST_SPL_EV: begin
            cmd.op   = OP_SPL_EV;
            state_in = status.layer_le ? ST_SPL_RD : ST_SPL_W1;
         end
         ST_SPL_W1: begin
            cmd.op   = OP_SPL_W1;
            state_in = ST_SPL_W2;
         end
         ST_SPL_W2: begin
            cmd.op   = OP_SPL_W2;
            state_in = (status.mode == MODE_INSERT) ? ST_INS_FIN : ST_SRT_ADV;
         end
         ST_INS_FIN: begin
            cmd.op   = OP_INS_FIN;
            state_in = ST_DONE;
         end
         ST_FND_RD: begin
            if (status.w_go) begin
               cmd.op   = OP_W_RD;
               state_in = ST_FND_EV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FND_EV: begin
            cmd.op = OP_FND_EV;
            if (!status.tag_hit) begin
               state_in = ST_FND_RD;
            end else if (status.mode == MODE_RELAYER) begin
               state_in = ST_RLY_W;
            end else begin
               state_in = ST_RM_W1;
            end
         end
         ST_RLY_W: begin
            cmd.op   = OP_RLY_W;
            state_in = ST_DONE;
         end
         ST_RM_W1: begin
            cmd.op   = OP_RM_W1;
            state_in = ST_RM_W2;
         end
         ST_RM_W2: begin
            cmd.op   = OP_RM_W2;
            state_in = ST_DONE;
         end
         ST_SRT_RD0: begin
            if (status.head_ok) begin
               cmd.op   = OP_SRT_RD0;
               state_in = ST_SRT_INIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SRT_INIT: begin
            cmd.op   = OP_SRT_INIT;
            state_in = ST_SRT_RD;
         end
         ST_SRT_RD: begin
            if (status.s_go) begin
               cmd.op   = OP_SRT_RD;
               state_in = ST_SRT_EV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SRT_EV: begin
            // an out of order entry is unlinked here and spliced back in
            cmd.op   = OP_SRT_EV;
            state_in = status.sort_less ? ST_SPL_RD : ST_SRT_RD;
         end
         ST_SRT_ADV: begin
            cmd.op   = OP_SRT_ADV;
            state_in = ST_SRT_RD;
         end
         ST_RD_RD: begin
            if (status.slot_ok) begin
               cmd.op   = OP_RD_RD;
               state_in = ST_RD_EV;
            end else begin
               cmd.op   = OP_RD_OUT;
               state_in = ST_DONE;
            end
         end
         ST_RD_EV: begin
            cmd.op   = OP_RD_EV;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_DONE;
               rsp_valid_in = 1'b1;
               clr_item_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         rsp_valid_ff <= 1'b0;
         clr_item_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_item_ff  <= clr_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/ldl_dp.sv @@
// ----------------------------------------------------------------------------
// ldl_dp
// slot memories, list pointers, walk registers and result registers
// ----------------------------------------------------------------------------
module ldl_dp import ldl_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [TAG_W-1:0]   req_tag,
   input  logic [LAYER_W-1:0] req_layer,
   input  logic [SLOT_W-1:0]  req_slot,
   output logic               rsp_ok,
   output logic [CNT_W-1:0]   rsp_count,
   output logic [CNT_W-1:0]   rsp_head_slot,
   output logic [TAG_W-1:0]   rsp_entry_tag,
   output logic [LAYER_W-1:0] rsp_entry_layer,
   output logic [CNT_W-1:0]   rsp_next_slot
);

   localparam int IW = $clog2(SLOTS);
   localparam int LW = $clog2(SLOTS + 1);
   localparam logic [LW-1:0] END_MARK = LW'(SLOTS);

   function automatic logic in_pool(input logic [LW-1:0] v);
      return v < END_MARK;
   endfunction

   // list pointers and walk registers
   logic [LW-1:0]      free_head_ff, free_head_in;
   logic [LW-1:0]      list_head_ff, list_head_in;
   logic [LW-1:0]      count_ff, count_in;
   logic [IW-1:0]      clr_ff, clr_in;
   logic [LW-1:0]      w_prev_ff, w_prev_in;
   logic [LW-1:0]      w_cur_ff, w_cur_in;
   logic [LW-1:0]      w_steps_ff, w_steps_in;
   logic [LW-1:0]      s_prev_ff, s_prev_in;
   logic [LW-1:0]      s_cur_ff, s_cur_in;
   logic [LW-1:0]      s_steps_ff, s_steps_in;
   // payload
   logic [IW-1:0]      s_ff, s_in;
   logic [LAYER_W-1:0] key_ff, key_in;
   logic [LW-1:0]      nx_ff, nx_in;
   logic [LAYER_W-1:0] s_layer_ff, s_layer_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [LAYER_W-1:0] layer_ff, layer_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               ok_ff, ok_in;
   logic [TAG_W-1:0]   etag_ff, etag_in;
   logic [LAYER_W-1:0] elayer_ff, elayer_in;
   logic [LW-1:0]      enext_ff, enext_in;
   logic               r_ok_ff, r_ok_in;
   logic [CNT_W-1:0]   r_count_ff, r_count_in;
   logic [CNT_W-1:0]   r_head_ff, r_head_in;
   logic [TAG_W-1:0]   r_tag_ff, r_tag_in;
   logic [LAYER_W-1:0] r_layer_ff, r_layer_in;
   logic [CNT_W-1:0]   r_next_ff, r_next_in;

   // memory ports
   logic               link_we, tag_we, layer_we;
   logic [IW-1:0]      link_wa, tag_wa, layer_wa, rd_addr;
   logic [LW-1:0]      link_wd, link_rd;
   logic [TAG_W-1:0]   tag_wd, tag_rd;
   logic [LAYER_W-1:0] layer_wd, layer_rd;

   ldl_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
      .clock(clock), .wr_en(link_we), .wr_addr(link_wa), .wr_data(link_wd),
      .rd_addr(rd_addr), .rd_data(link_rd)
   );
   ldl_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag_ram (
      .clock(clock), .wr_en(tag_we), .wr_addr(tag_wa), .wr_data(tag_wd),
      .rd_addr(rd_addr), .rd_data(tag_rd)
   );
   ldl_ram #(.WIDTH(LAYER_W), .DEPTH(SLOTS)) u_layer_ram (
      .clock(clock), .wr_en(layer_we), .wr_addr(layer_wa), .wr_data(layer_wd),
      .rd_addr(rd_addr), .rd_data(layer_rd)
   );

   always_comb begin
      status.mode      = mode_ff;
      status.free_ok   = in_pool(free_head_ff);
      status.head_ok   = in_pool(list_head_ff);
      status.w_go      = in_pool(w_cur_ff) && (w_steps_ff < END_MARK);
      status.layer_le  = layer_rd <= key_ff;
      status.tag_hit   = tag_rd == tag_ff;
      status.s_go      = in_pool(s_cur_ff) && (s_steps_ff < END_MARK);
      status.sort_less = layer_rd < s_layer_ff;
      status.slot_ok   = 32'(slot_ff) < SLOTS;
      status.clr_last  = clr_ff == IW'(SLOTS - 1);
   end

   always_comb begin
      free_head_in = free_head_ff;
      list_head_in = list_head_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      w_prev_in    = w_prev_ff;
      w_cur_in     = w_cur_ff;
      w_steps_in   = w_steps_ff;
      s_prev_in    = s_prev_ff;
      s_cur_in     = s_cur_ff;
      s_steps_in   = s_steps_ff;
      s_in         = s_ff;
      key_in       = key_ff;
      nx_in        = nx_ff;
      s_layer_in   = s_layer_ff;
      mode_in      = mode_ff;
      tag_in       = tag_ff;
      layer_in     = layer_ff;
      slot_in      = slot_ff;
      ok_in        = ok_ff;
      etag_in      = etag_ff;
      elayer_in    = elayer_ff;
      enext_in     = enext_ff;
      r_ok_in      = r_ok_ff;
      r_count_in   = r_count_ff;
      r_head_in    = r_head_ff;
      r_tag_in     = r_tag_ff;
      r_layer_in   = r_layer_ff;
      r_next_in    = r_next_ff;
      link_we      = 1'b0;
      link_wa      = '0;
      link_wd      = '0;
      tag_we       = 1'b0;
      tag_wa       = '0;
      tag_wd       = '0;
      layer_we     = 1'b0;
      layer_wa     = '0;
      layer_wd     = '0;
      rd_addr      = '0;
      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_ACCEPT: begin
            mode_in    = req_mode;
            tag_in     = req_tag;
            layer_in   = req_layer;
            slot_in    = req_slot;
            ok_in      = 1'b0;
            etag_in    = '0;
            elayer_in  = '0;
            enext_in   = '0;
            w_prev_in  = END_MARK;
            w_cur_in   = list_head_ff;
            w_steps_in = '0;
         end
         OP_CLR_STEP: begin
            link_we  = 1'b1;
            link_wa  = clr_ff;
            link_wd  = LW'(clr_ff) + LW'(1);
            tag_we   = 1'b1;
            tag_wa   = clr_ff;
            layer_we = 1'b1;
            layer_wa = clr_ff;
            clr_in   = status.clr_last ? '0 : clr_ff + IW'(1);
         end
         OP_CLR_END: begin
            free_head_in = '0;
            list_head_in = END_MARK;
            count_in     = '0;
         end
         OP_INS_RD: rd_addr = free_head_ff[IW-1:0];
         OP_INS_TAKE: begin
            s_in         = free_head_ff[IW-1:0];
            free_head_in = link_rd;
            tag_we       = 1'b1;
            tag_wa       = free_head_ff[IW-1:0];
            tag_wd       = tag_ff;
            layer_we     = 1'b1;
            layer_wa     = free_head_ff[IW-1:0];
            layer_wd     = layer_ff;
            key_in       = layer_ff;
            w_prev_in    = END_MARK;
            w_cur_in     = list_head_ff;
            w_steps_in   = '0;
         end
         OP_W_RD: rd_addr = w_cur_ff[IW-1:0];
         OP_SPL_EV: begin
            if (status.layer_le) begin
               w_prev_in  = w_cur_ff;
               w_cur_in   = link_rd;
               w_steps_in = w_steps_ff + LW'(1);
            end
         end
         OP_SPL_W1: begin
            link_we = 1'b1;
            link_wa = s_ff;
            link_wd = in_pool(w_cur_ff) ? w_cur_ff : END_MARK;
         end
         OP_SPL_W2: begin
            if (in_pool(w_prev_ff)) begin
               link_we = 1'b1;
               link_wa = w_prev_ff[IW-1:0];
               link_wd = LW'(s_ff);
            end else begin
               list_head_in = LW'(s_ff);
            end
         end
         OP_INS_FIN: begin
            count_in = count_ff + LW'(1);
            ok_in    = 1'b1;
         end
         OP_FND_EV: begin
            if (status.tag_hit) begin
               s_in  = w_cur_ff[IW-1:0];
               nx_in = link_rd;
            end else begin
               w_prev_in  = w_cur_ff;
               w_cur_in   = link_rd;
               w_steps_in = w_steps_ff + LW'(1);
            end
         end
         OP_RLY_W: begin
            layer_we = 1'b1;
            layer_wa = s_ff;
            layer_wd = layer_ff;
            ok_in    = 1'b1;
         end
         OP_RM_W1: begin
            if (in_pool(w_prev_ff)) begin
               link_we = 1'b1;
               link_wa = w_prev_ff[IW-1:0];
               link_wd = nx_ff;
            end else begin
               list_head_in = nx_ff;
            end
         end
         OP_RM_W2: begin
            link_we      = 1'b1;
            link_wa      = s_ff;
            link_wd      = free_head_ff;
            free_head_in = LW'(s_ff);
            if (count_ff != '0) begin
               count_in = count_ff - LW'(1);
            end
            ok_in = 1'b1;
         end
         OP_SRT_RD0: rd_addr = list_head_ff[IW-1:0];
         OP_SRT_INIT: begin
            s_prev_in  = list_head_ff;
            s_layer_in = layer_rd;
            s_cur_in   = link_rd;
            s_steps_in = '0;
         end
         OP_SRT_RD: rd_addr = s_cur_ff[IW-1:0];
         OP_SRT_EV: begin
            nx_in = link_rd;
            if (status.sort_less) begin
               link_we    = 1'b1;
               link_wa    = s_prev_ff[IW-1:0];
               link_wd    = link_rd;
               s_in       = s_cur_ff[IW-1:0];
               key_in     = layer_rd;
               w_prev_in  = END_MARK;
               w_cur_in   = list_head_ff;
               w_steps_in = '0;
            end else begin
               s_prev_in  = s_cur_ff;
               s_layer_in = layer_rd;
               s_cur_in   = link_rd;
               s_steps_in = s_steps_ff + LW'(1);
            end
         end
         OP_SRT_ADV: begin
            s_cur_in   = nx_ff;
            s_steps_in = s_steps_ff + LW'(1);
         end
         OP_RD_RD: rd_addr = IW'(slot_ff);
         OP_RD_EV: begin
            ok_in     = 1'b1;
            etag_in   = tag_rd;
            elayer_in = layer_rd;
            enext_in  = link_rd;
         end
         OP_RD_OUT: enext_in = END_MARK;
         OP_DONE: begin
            r_ok_in    = ok_ff;
            r_count_in = CNT_W'(count_ff);
            r_head_in  = CNT_W'(list_head_ff);
            r_tag_in   = etag_ff;
            r_layer_in = elayer_ff;
            r_next_in  = CNT_W'(enext_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         list_head_ff <= END_MARK;
         count_ff     <= '0;
         clr_ff       <= '0;
         w_prev_ff    <= END_MARK;
         w_cur_ff     <= END_MARK;
         w_steps_ff   <= '0;
         s_prev_ff    <= END_MARK;
         s_cur_ff     <= END_MARK;
         s_steps_ff   <= '0;
      end else begin
         free_head_ff <= free_head_in;
         list_head_ff <= list_head_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         w_prev_ff    <= w_prev_in;
         w_cur_ff     <= w_cur_in;
         w_steps_ff   <= w_steps_in;
         s_prev_ff    <= s_prev_in;
         s_cur_ff     <= s_cur_in;
         s_steps_ff   <= s_steps_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff       <= s_in;
      key_ff     <= key_in;
      nx_ff      <= nx_in;
      s_layer_ff <= s_layer_in;
      mode_ff    <= mode_in;
      tag_ff     <= tag_in;
      layer_ff   <= layer_in;
      slot_ff    <= slot_in;
      ok_ff      <= ok_in;
      etag_ff    <= etag_in;
      elayer_ff  <= elayer_in;
      enext_ff   <= enext_in;
      r_ok_ff    <= r_ok_in;
      r_count_ff <= r_count_in;
      r_head_ff  <= r_head_in;
      r_tag_ff   <= r_tag_in;
      r_layer_ff <= r_layer_in;
      r_next_ff  <= r_next_in;
   end

   assign rsp_ok          = r_ok_ff;
   assign rsp_count       = r_count_ff;
   assign rsp_head_slot   = r_head_ff;
   assign rsp_entry_tag   = r_tag_ff;
   assign rsp_entry_layer = r_layer_ff;
   assign rsp_next_slot   = r_next_ff;

endmodule

@@ rtl/ldl_checker.sv @@
// ----------------------------------------------------------------------------
// ldl_checker
// port level checks on the display list block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ldl_checker import ldl_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_ok,
   input logic [CNT_W-1:0]   rsp_count,
   input logic [TAG_W-1:0]   rsp_entry_tag,
   input logic [LAYER_W-1:0] rsp_entry_layer
);

   // a waiting result is not dropped
   `LDL_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result item dropped")

   // one item in flight: ready falls right after an accept
   `LDL_ASSERT(a_one_item, req_valid && req_ready |=> !req_ready, "second item taken")

   // entry count never passes the pool size
   `LDL_ASSERT(a_count_max, rsp_valid |-> 32'(rsp_count) <= SLOTS, "count past pool size")

   // a failed item reports an empty entry
   `LDL_ASSERT_CLK(a_fail_zero, clock, reset,
      rsp_valid && !rsp_ok |-> rsp_entry_tag == '0 && rsp_entry_layer == '0,
      "entry fields set on failed item")

endmodule

bind layer_ordered_display_list_top ldl_checker #(.SLOTS(SLOTS)) u_ldl_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_ok(rsp_ok), .rsp_count(rsp_count),
   .rsp_entry_tag(rsp_entry_tag), .rsp_entry_layer(rsp_entry_layer)
);
